FILE: sv/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared constants and types for the UTF-8 decoder with replacement.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // Byte classification masks and patterns
    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // Payload masks
    localparam logic [7:0] CONT_BITS  = 8'h3F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;

    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One job: a burst of replacement results, then an optional tail result
    typedef struct packed {
        logic [1:0]      pre_count;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_rep;
        logic            fin;
    } job_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: sv/utf8d_in_if.sv
// ----------------------------------------------------------------------------
// utf8d_in_if
// Byte channel into the decoder: valid/ready with one text byte.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

FILE: sv/utf8d_out_if.sv
// ----------------------------------------------------------------------------
// utf8d_out_if
// Code point channel out of the decoder: valid/ready with one result.
// ----------------------------------------------------------------------------
interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic        run_end;
    logic        text_end;

    modport source (output valid, output code_point, output replaced,
                    output run_end, output text_end, input ready);
    modport sink   (input valid, input code_point, input replaced,
                    input run_end, input text_end, output ready);
endinterface

FILE: sv/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks the open sequence and turns each byte that yields results into a job.
// ----------------------------------------------------------------------------
module utf8d_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    utf8d_in_if.sink             text,
    input  utf8d_pkg::fifo_stat_t stat,
    output logic                 push,
    output utf8d_pkg::job_t      job
);

    typedef struct packed {
        logic                       emit;
        logic                       rep;
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic                       open;
        logic [1:0]                 need;
    } lead_t;

    // Lead byte decode; a multibyte lead on the final byte is replaced
    function automatic lead_t decode_lead(input logic [7:0] b, input logic fin);
        lead_t r;
        r = '0;
        if ((b & utf8d_pkg::LEAD1_MASK) == 8'h00)
        begin
            r.emit = 1'b1;
            r.cp   = {13'd0, b};
        end
        else if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT)
        begin
            r.open = 1'b1;
            r.need = 2'd1;
            r.cp   = {13'd0, b & utf8d_pkg::LEAD2_BITS};
        end
        else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT)
        begin
            r.open = 1'b1;
            r.need = 2'd2;
            r.cp   = {13'd0, b & utf8d_pkg::LEAD3_BITS};
        end
        else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT)
        begin
            r.open = 1'b1;
            r.need = 2'd3;
            r.cp   = {13'd0, b & utf8d_pkg::LEAD4_BITS};
        end
        else
        begin
            r.emit = 1'b1;
            r.rep  = 1'b1;
            r.cp   = utf8d_pkg::REPLACEMENT_CP;
        end
        if (r.open && fin)
        begin
            r.open = 1'b0;
            r.emit = 1'b1;
            r.rep  = 1'b1;
            r.cp   = utf8d_pkg::REPLACEMENT_CP;
        end
        return r;
    endfunction

    logic [1:0]                 exp_reg, exp_next;
    logic [1:0]                 seen_reg, seen_next;
    logic [utf8d_pkg::CP_W-1:0] part_reg, part_next;

    lead_t                      lead;
    logic                       is_cont;
    logic                       accept;
    logic [1:0]                 seen_inc;
    logic [7:0]                 cont_byte;
    logic [utf8d_pkg::CP_W-1:0] part_shift;

    assign text.ready = !stat.full;
    assign accept     = text.valid && text.ready;

    // Classification and next state
    always_comb
    begin
        lead       = decode_lead(text.text_byte, text.final_byte);
        is_cont    = (text.text_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_PAT;
        seen_inc   = seen_reg + 2'd1;
        cont_byte  = text.text_byte & utf8d_pkg::CONT_BITS;
        part_shift = {part_reg[utf8d_pkg::CP_W-7:0], cont_byte[5:0]};

        exp_next  = exp_reg;
        seen_next = seen_reg;
        part_next = part_reg;
        job       = '0;
        job.fin   = text.final_byte;

        if (exp_reg == 2'd0)
        begin
            job.has_tail = lead.emit;
            job.tail_cp  = lead.cp;
            job.tail_rep = lead.rep;
            if (lead.open)
            begin
                exp_next  = lead.need;
                seen_next = 2'd0;
                part_next = lead.cp;
            end
        end
        else if (text.final_byte && ((exp_reg - seen_reg) > 2'd1))
        begin
            // truncated at end of text
            job.has_tail = 1'b1;
            job.tail_cp  = utf8d_pkg::REPLACEMENT_CP;
            job.tail_rep = 1'b1;
        end
        else if (is_cont)
        begin
            part_next = part_shift;
            seen_next = seen_inc;
            if (seen_inc == exp_reg)
            begin
                job.has_tail = 1'b1;
                job.tail_cp  = part_shift;
                job.tail_rep = 1'b0;
                exp_next     = 2'd0;
                seen_next    = 2'd0;
                part_next    = '0;
            end
        end
        else
        begin
            // broken sequence: one replacement per buffered byte, then relead
            job.pre_count = seen_inc;
            job.has_tail  = lead.emit;
            job.tail_cp   = lead.cp;
            job.tail_rep  = lead.rep;
            if (lead.open)
            begin
                exp_next  = lead.need;
                seen_next = 2'd0;
                part_next = lead.cp;
            end
            else
            begin
                exp_next  = 2'd0;
                seen_next = 2'd0;
                part_next = '0;
            end
        end

        if (text.final_byte)
        begin
            exp_next  = 2'd0;
            seen_next = 2'd0;
            part_next = '0;
        end

        push = accept && (job.has_tail || (job.pre_count != 2'd0));
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= 2'd0;
            seen_reg <= 2'd0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
            part_reg <= part_next;
        end
    end

endmodule

FILE: sv/utf8d_fifo.sv
// ----------------------------------------------------------------------------
// utf8d_fifo
// Small job queue decoupling the classifier from the result sequencer.
// ----------------------------------------------------------------------------
module utf8d_fifo
#(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  utf8d_pkg::job_t       push_job,
    input  logic                  pop,
    output utf8d_pkg::job_t       head_job,
    output utf8d_pkg::fifo_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::job_t  store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = store[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Takes jobs from the queue and plays out their results one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module utf8d_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  utf8d_pkg::job_t       head_job,
    input  utf8d_pkg::fifo_stat_t stat,
    output logic                  pop,
    utf8d_out_if.source           points
);

    utf8d_pkg::job_t job_reg;
    logic            job_valid_reg, job_valid_next;
    logic [1:0]      idx_reg, idx_next;
    logic [2:0]      total;
    logic            last;
    logic            in_pre;
    logic            fire;

    assign total  = {1'b0, job_reg.pre_count} + {2'b00, job_reg.has_tail};
    assign last   = ({1'b0, idx_reg} + 3'd1) == total;
    assign in_pre = idx_reg < job_reg.pre_count;
    assign fire   = points.valid && points.ready;
    assign pop    = !stat.empty && (!job_valid_reg || (fire && last));

    // Result fields from the held job
    assign points.valid      = job_valid_reg;
    assign points.code_point = in_pre ? utf8d_pkg::REPLACEMENT_CP : job_reg.tail_cp;
    assign points.replaced   = in_pre ? 1'b1 : job_reg.tail_rep;
    assign points.run_end    = last;
    assign points.text_end   = last && job_reg.fin;

    // Sequencer control
    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            job_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (fire && last)
        begin
            job_valid_next = 1'b0;
            idx_next       = 2'd0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Job payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
    end

endmodule

FILE: sv/utf8_decoder_with_replacement_unit.sv
// A byte's job is written into the job queue when the byte is accepted, then loaded
// into the sequencer's job register, after which its first result is valid.
// Throughput: one byte per cycle; each result is its own output transfer, so a
// malformed byte with up to four results holds the sequencer until all are taken.
// The job queue (QUEUE_DEPTH entries) absorbs such bursts; input stalls when full.
// Reset clears the open sequence, the queue and the output stage at once.
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement_unit
// UTF-8 byte stream to code points, with U+FFFD on malformed input.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement_unit
#(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    text,
    utf8d_out_if.source points
);

    utf8d_pkg::job_t       push_job;
    utf8d_pkg::job_t       head_job;
    utf8d_pkg::fifo_stat_t stat;
    logic                  push;
    logic                  pop;

    // Classifier
    utf8d_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .stat  (stat),
        .push  (push),
        .job   (push_job)
    );

    // Job queue
    utf8d_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

    // Result sequencer
    utf8d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .stat     (stat),
        .pop      (pop),
        .points   (points)
    );

    // Checks
    a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue full and empty together");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !push || !text.ready)
        else $error("job pushed into full queue");

    a_text_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && points.text_end) |-> points.run_end)
        else $error("text end on a result that is not the last of its byte");

    a_replaced_value: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && points.replaced) |-> (points.code_point == utf8d_pkg::REPLACEMENT_CP))
        else $error("replaced result without U+FFFD");

endmodule
